// ----- rtl/bra_pkg.sv -----
// Package for the banker's resource allocator.
// Operation, status and register codes, shared types. No dependencies.
`timescale 1ns / 1ps
package bra_pkg;

	localparam logic [2:0] FUNC_CONNECT    = 3'd0;
	localparam logic [2:0] FUNC_DISCONNECT = 3'd1;
	localparam logic [2:0] FUNC_CLAIM      = 3'd2;
	localparam logic [2:0] FUNC_REQUEST    = 3'd3;
	localparam logic [2:0] FUNC_RELEASE    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD     = 3'd1;
	localparam logic [2:0] ST_UNAVAIL = 3'd2;
	localparam logic [2:0] ST_UNSAFE  = 3'd3;
	localparam logic [2:0] ST_EXCEEDS = 3'd4;

	localparam logic [1:0] CFG_THREADS   = 2'd0;
	localparam logic [1:0] CFG_RESOURCES = 2'd1;
	localparam logic [1:0] CFG_AVOID     = 2'd2;

	localparam logic [4:0] THREADS_RESET   = 5'd16;
	localparam logic [3:0] RESOURCES_RESET = 4'd8;

	localparam int HDR_W = 7;

	typedef struct packed {
		logic [4:0] thread_count;
		logic [3:0] resource_count;
		logic       avoid_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0] func;
		logic [3:0] thread;
	} op_hdr_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CHECK,
		B_EXEC,
		B_SCAN_RD,
		B_SCAN_EV,
		B_SCAN_END,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/bra_queue.sv -----
// Two-entry operation queue between front and back.
// Depends on nothing.
`timescale 1ns / 1ps
module bra_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output logic [WIDTH-1:0] q_data
);
	logic [WIDTH-1:0] ent_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) ent_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && q_valid);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");

endmodule

// ----- rtl/bra_front.sv -----
// Front end: collects element items into a pending vector, queues operations.
// Depends on bra_pkg.
`timescale 1ns / 1ps
module bra_front import bra_pkg::*; #(
	parameter int MAX_RESOURCES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [2:0]                           func,
	input  logic [3:0]                           thread,
	input  logic [2:0]                           resource,
	input  logic [3:0]                           amount,
	input  logic                                 last,
	input  logic                                 q_full,
	output logic                                 push,
	output logic [HDR_W+MAX_RESOURCES*4-1:0]     push_data
);
	localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

	logic [MAX_RESOURCES-1:0][3:0] pend_q, merged;
	logic                          take;
	op_hdr_t                       hdr;

	assign item_stall = q_full;
	assign take       = item_valid && !q_full;

	always_comb begin
		merged = pend_q;
		if (32'(resource) < MAX_RESOURCES) merged[RW'(resource)] = amount;
	end

	assign hdr.func   = func;
	assign hdr.thread = thread;
	assign push       = take && last && (func <= FUNC_RELEASE);
	assign push_data  = {hdr, merged};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (take) begin
			if (last) pend_q <= '0;
			else pend_q <= merged;
		end
	end

endmodule

// ----- rtl/bra_back.sv -----
// Back end: executes queued operations on the allocation and claim tables,
// runs the safety check and holds the result register. Depends on bra_pkg.
`timescale 1ns / 1ps
module bra_back import bra_pkg::*; #(
	parameter int MAX_THREADS   = 16,
	parameter int MAX_RESOURCES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             q_valid,
	input  logic [HDR_W+MAX_RESOURCES*4-1:0] q_data,
	output logic                             pop,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [2:0]                       status,
	output logic [3:0]                       thread_echo
);
	localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int R  = MAX_RESOURCES;

	typedef logic [R-1:0][3:0] row_t;

	back_state_t state_q, state_d;

	row_t                  claim_mem [MAX_THREADS];
	row_t                  alloc_mem [MAX_THREADS];
	row_t                  claim_rd_q, alloc_rd_q;
	logic                  rvld_rd_q;
	logic [MAX_THREADS-1:0] row_vld_q;
	logic [MAX_THREADS-1:0] conn_q;
	logic [MAX_THREADS-1:0] fin_q;
	logic [R-1:0][3:0]     avail_q;
	logic [R-1:0][7:0]     work_q;
	op_hdr_t               op_q;
	row_t                  pend_q, nalloc_q;
	logic [2:0]            st_q;
	logic [CW-1:0]         xidx_q;
	logic                  prog_q;
	logic                  res_valid_q;
	logic [2:0]            res_status_q;
	logic [3:0]            res_thread_q;

	logic [CW-1:0]  eff_tc;
	logic [R-1:0]   use_r;
	logic [TW-1:0]  tidx, xaddr, rd_addr, wr_addr;
	logic           wr_en;
	row_t           wr_claim, wr_alloc;
	row_t           row_c, row_a, a_x, a_plus, a_minus, c_new;
	logic           bad_thread, unavail, exceeds, fits, all_fin, out_free;

	assign eff_tc   = (32'(cfg.thread_count) > MAX_THREADS) ? CW'(MAX_THREADS)
	                                                     : CW'(cfg.thread_count);
	assign tidx     = TW'(op_q.thread);
	assign xaddr    = TW'(xidx_q);
	assign out_free = !res_valid_q || !result_stall;
	assign bad_thread = ({1'b0, op_q.thread} >= 5'(eff_tc));

	always_comb begin
		for (int r = 0; r < R; r++)
			use_r[r] = (r < 32'(cfg.resource_count));
	end

	assign row_c = rvld_rd_q ? claim_rd_q : '0;
	assign row_a = rvld_rd_q ? alloc_rd_q : '0;
	assign a_x   = (xaddr == tidx) ? nalloc_q : row_a;

	always_comb begin
		unavail = 1'b0;
		exceeds = 1'b0;
		fits    = 1'b1;
		for (int r = 0; r < R; r++) begin
			a_plus[r]  = use_r[r] ? row_a[r] + pend_q[r] : row_a[r];
			a_minus[r] = use_r[r] ? row_a[r] - pend_q[r] : row_a[r];
			c_new[r]   = use_r[r] ? pend_q[r] : row_c[r];
			if (use_r[r]) begin
				if (pend_q[r] > avail_q[r] ||
				    ({1'b0, pend_q[r]} + {1'b0, row_a[r]}) > {1'b0, row_c[r]})
					unavail = 1'b1;
				if (pend_q[r] > row_a[r]) exceeds = 1'b1;
				if (row_c[r] > a_x[r] && 8'(row_c[r] - a_x[r]) > work_q[r])
					fits = 1'b0;
			end
		end
		all_fin = 1'b1;
		for (int x = 0; x < MAX_THREADS; x++)
			if (x < 32'(eff_tc) && !fin_q[x]) all_fin = 1'b0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:     if (q_valid) state_d = B_CHECK;
			B_CHECK: begin
				if (bad_thread || op_q.func == FUNC_CONNECT || !conn_q[tidx] ||
				    op_q.func == FUNC_DISCONNECT)
					state_d = B_DONE;
				else
					state_d = B_EXEC;
			end
			B_EXEC: begin
				if (op_q.func == FUNC_REQUEST && !unavail && cfg.avoid_enable)
					state_d = B_SCAN_RD;
				else
					state_d = B_DONE;
			end
			B_SCAN_RD:  state_d = (xidx_q == eff_tc) ? B_SCAN_END : B_SCAN_EV;
			B_SCAN_EV:  state_d = B_SCAN_RD;
			B_SCAN_END: state_d = prog_q ? B_SCAN_RD : B_DONE;
			B_DONE:     if (out_free) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		rd_addr  = tidx;
		wr_en    = 1'b0;
		wr_addr  = tidx;
		wr_claim = row_c;
		wr_alloc = row_a;
		case (state_q)
			B_IDLE:    pop = q_valid;
			B_SCAN_RD: rd_addr = (xidx_q == eff_tc) ? tidx : xaddr;
			B_EXEC: begin
				if (op_q.func == FUNC_CLAIM) begin
					wr_en    = 1'b1;
					wr_claim = c_new;
				end else if (op_q.func == FUNC_RELEASE) begin
					wr_en    = !exceeds;
					wr_alloc = a_minus;
				end else begin
					wr_en    = !unavail && !cfg.avoid_enable;
					wr_alloc = a_plus;
				end
			end
			B_SCAN_END: begin
				wr_en    = !prog_q && all_fin;
				wr_alloc = nalloc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			claim_mem[wr_addr] <= wr_claim;
			alloc_mem[wr_addr] <= wr_alloc;
		end
		if (state_q != B_SCAN_END) begin
			claim_rd_q <= claim_mem[rd_addr];
			alloc_rd_q <= alloc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				op_q   <= op_hdr_t'(q_data[HDR_W+R*4-1 -: HDR_W]);
				pend_q <= row_t'(q_data[R*4-1:0]);
			end
			B_EXEC: begin
				nalloc_q <= a_plus;
				xidx_q   <= '0;
				prog_q   <= 1'b0;
				fin_q    <= '0;
				for (int r = 0; r < R; r++)
					work_q[r] <= 8'(avail_q[r] - pend_q[r]);
			end
			B_SCAN_EV: begin
				xidx_q <= xidx_q + 1'b1;
				if (!fin_q[xaddr] && fits) begin
					fin_q[xaddr] <= 1'b1;
					prog_q       <= 1'b1;
					for (int r = 0; r < R; r++)
						if (use_r[r]) work_q[r] <= work_q[r] + 8'(a_x[r]);
				end
			end
			B_SCAN_END: begin
				prog_q <= 1'b0;
				xidx_q <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			row_vld_q   <= '0;
			rvld_rd_q   <= 1'b0;
			conn_q      <= '0;
			res_valid_q <= 1'b0;
			st_q        <= ST_OK;
			for (int r = 0; r < R; r++) avail_q[r] <= 4'd1;
		end else begin
			state_q <= state_d;
			if (state_q != B_SCAN_END) rvld_rd_q <= row_vld_q[rd_addr];
			if (wr_en) row_vld_q[wr_addr] <= 1'b1;
			if (state_q == B_DONE && out_free) res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
			case (state_q)
				B_CHECK: begin
					if (bad_thread) st_q <= ST_BAD;
					else if (op_q.func == FUNC_CONNECT) begin
						st_q         <= ST_OK;
						conn_q[tidx] <= 1'b1;
					end else if (!conn_q[tidx]) st_q <= ST_BAD;
					else begin
						st_q <= ST_OK;
						if (op_q.func == FUNC_DISCONNECT) conn_q[tidx] <= 1'b0;
					end
				end
				B_EXEC: begin
					if (op_q.func == FUNC_RELEASE) begin
						if (exceeds) st_q <= ST_EXCEEDS;
						else for (int r = 0; r < R; r++)
							if (use_r[r])
								avail_q[r] <= (5'(avail_q[r]) + 5'(pend_q[r]) > 5'd15)
									? 4'd15 : avail_q[r] + pend_q[r];
					end else if (op_q.func == FUNC_REQUEST) begin
						if (unavail) st_q <= ST_UNAVAIL;
						else if (!cfg.avoid_enable)
							for (int r = 0; r < R; r++)
								if (use_r[r]) avail_q[r] <= avail_q[r] - pend_q[r];
					end
				end
				B_SCAN_END: begin
					if (!prog_q) begin
						if (all_fin) begin
							for (int r = 0; r < R; r++)
								if (use_r[r]) avail_q[r] <= avail_q[r] - pend_q[r];
						end else begin
							st_q <= ST_UNSAFE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DONE && out_free) begin
			res_status_q <= st_q;
			res_thread_q <= op_q.thread;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign thread_echo  = res_thread_q;

endmodule

// ----- rtl/bankers_resource_allocator_core.sv -----
// Banker's-algorithm resource allocator, top level.
// Instantiates bra_front, bra_queue and bra_back; depends on bra_pkg.
// An operation arrives as element items; on the last item an operation with a
// valid function code is queued and the back end answers with one result.
// Connect and disconnect finish after the check step; claim, release and a
// request without avoidance after the execute step. A request with avoidance
// that passes the availability check runs the safety scan through the single
// row-read port of the thread tables, up to threads+1 passes. The front keeps
// taking items while the back works, up to two queued operations.
`timescale 1ns / 1ps
module bankers_resource_allocator_core import bra_pkg::*; #(
	parameter int MAX_THREADS   = 16,
	parameter int MAX_RESOURCES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [2:0] func,
	input  logic [3:0] thread,
	input  logic [2:0] resource,
	input  logic [3:0] amount,
	input  logic       last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] status,
	output logic [3:0] thread_echo
);
	localparam int QW = HDR_W + MAX_RESOURCES * 4;

	cfg_t          cfg_q;
	logic          q_full, push, pop, q_valid;
	logic [QW-1:0] push_data, q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thread_count   <= THREADS_RESET;
			cfg_q.resource_count <= RESOURCES_RESET;
			cfg_q.avoid_enable   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_THREADS:   cfg_q.thread_count   <= cfg_data;
				CFG_RESOURCES: cfg_q.resource_count <= cfg_data[3:0];
				CFG_AVOID:     cfg_q.avoid_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bra_front #(.MAX_RESOURCES(MAX_RESOURCES)) u_front (
		.clk, .arst_n, .item_valid, .item_stall, .func, .thread, .resource,
		.amount, .last, .q_full, .push, .push_data
	);

	bra_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full), .pop, .q_valid, .q_data
	);

	bra_back #(.MAX_THREADS(MAX_THREADS), .MAX_RESOURCES(MAX_RESOURCES)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_data, .pop, .result_valid,
		.result_stall, .status, .thread_echo
	);

endmodule
